[design/rcwh_pkg.sv]
// ----------------------------------------------------------------------------
// rcwh_pkg
// Shared types and constants for the column ray caster.
// ----------------------------------------------------------------------------
package rcwh_pkg;

   localparam int unsigned RAD_BAU  = 10430;
   localparam int unsigned LINE_SAT = 64512;
   localparam int unsigned SIN_A    = 25736;
   localparam int unsigned SIN_B    = 10512;
   localparam int unsigned SIN_C    = 1160;

   // position width: Q8.16 plus sign plus headroom for overshoot
   localparam int unsigned POS_W = 28;

   typedef enum logic [2:0] {
      CSR_MAP_WALLS     = 3'd0,
      CSR_PLAYER_X      = 3'd1,
      CSR_PLAYER_Y      = 3'd2,
      CSR_PLAYER_ANGLE  = 3'd3,
      CSR_SCREEN_WIDTH  = 3'd4,
      CSR_SCREEN_HEIGHT = 3'd5,
      CSR_STEP_SIZE     = 3'd6
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_ANGLE,
      ST_TRIG,
      ST_DELTA,
      ST_MARCH,
      ST_SQUARE,
      ST_SQRT,
      ST_DIV_LINE,
      ST_FINISH,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;        // capture column, start angle divide
      logic div_step;    // one restoring divide step
      logic trig;        // one step of the sine and cosine polynomial
      logic delta;       // compute per step increments
      logic march;       // advance the ray one step
      logic square;      // form squared distance
      logic sqrt_step;   // one square root step
      logic line_init;   // start line height divide
      logic finish;      // compute output rows
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic trig_done;
      logic sqrt_done;
      logic march_stop;  // hit, left map or step cap
      logic hit;
   } status_type;

endpackage

[design/rcwh_ctrl.sv]
// ----------------------------------------------------------------------------
// rcwh_ctrl
// Sequencer for the column ray caster.
// ----------------------------------------------------------------------------
module rcwh_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rcwh_pkg::status_type status,
   output rcwh_pkg::cmd_type    cmd
);
   import rcwh_pkg::*;

   state_type state_ff, state_in;
   logic      after_ff, after_in; // 0: angle divide, 1: line divide

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         after_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         after_ff <= after_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      after_in = after_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DIV_ANGLE;
               after_in = 1'b0;
            end
         end
         ST_DIV_ANGLE: begin
            if (status.div_done) state_in = after_ff ? ST_FINISH : ST_TRIG;
         end
         ST_TRIG: begin
            if (status.trig_done) state_in = ST_DELTA;
         end
         ST_DELTA: state_in = ST_MARCH;
         ST_MARCH: begin
            if (status.march_stop) state_in = status.hit ? ST_SQUARE : ST_FINISH;
         end
         ST_SQUARE: state_in = ST_SQRT;
         ST_SQRT: begin
            if (status.sqrt_done) state_in = ST_DIV_LINE;
         end
         ST_DIV_LINE: begin
            state_in = ST_DIV_ANGLE;
            after_in = 1'b1;
         end
         ST_FINISH: state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_DIV_ANGLE: cmd.div_step  = 1'b1;
         ST_TRIG:      cmd.trig      = 1'b1;
         ST_DELTA:     cmd.delta     = 1'b1;
         ST_MARCH:     cmd.march     = 1'b1;
         ST_SQUARE:    cmd.square    = 1'b1;
         ST_SQRT:      cmd.sqrt_step = 1'b1;
         ST_DIV_LINE:  cmd.line_init = 1'b1;
         ST_FINISH:    cmd.finish    = 1'b1;
         ST_OUT:       rsp_valid     = 1'b1;
         default:      cmd           = '0;
      endcase
   end

endmodule

[design/rcwh_datapath.sv]
// ----------------------------------------------------------------------------
// rcwh_datapath
// Registers, shared divider, trig unit, square root unit and ray stepper.
// ----------------------------------------------------------------------------
module rcwh_datapath #(
   parameter int MAP_DIM         = 8,
   parameter int MAX_STEPS       = 2048,
   parameter int TRIG_TABLE_BITS = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [2:0]           csr_index,
   input  logic [63:0]          csr_data,
   input  logic [9:0]           req_column,
   input  rcwh_pkg::cmd_type    cmd,
   output rcwh_pkg::status_type status,
   output logic [9:0]           rsp_column_out,
   output logic                 rsp_wall_hit,
   output logic signed [15:0]   rsp_line_top,
   output logic signed [15:0]   rsp_line_bottom
);
   import rcwh_pkg::*;

   localparam int CNT_W  = $clog2(MAX_STEPS + 1);
   localparam int CELL_W = $clog2(MAP_DIM);
   localparam int DIV_N  = 32;  // dividend width (covers 1023<<16 and 1023*10430)
   localparam int DIV_CW = $clog2(DIV_N + 1);
   localparam int SQ_W   = 2 * POS_W;
   localparam int SQ_CW  = $clog2(SQ_W / 2 + 1);

   // trig unit phases
   localparam logic [2:0] TR_ANGLE  = 3'd0;
   localparam logic [2:0] TR_SQUARE = 3'd1;
   localparam logic [2:0] TR_POLY_C = 3'd2;
   localparam logic [2:0] TR_POLY_B = 3'd3;
   localparam logic [2:0] TR_SCALE  = 3'd4;
   localparam logic [2:0] TR_DONE   = 3'd5;

   // configuration
   logic [63:0] walls_ff;
   logic [18:0] px_ff, py_ff;
   logic [15:0] pang_ff, step_ff;
   logic [9:0]  sw_ff, sh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         walls_ff <= 64'd460039;
         px_ff    <= 19'd98304;
         py_ff    <= 19'd98304;
         pang_ff  <= 16'd0;
         sw_ff    <= 10'd640;
         sh_ff    <= 10'd480;
         step_ff  <= 16'd655;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MAP_WALLS:     walls_ff <= csr_data;
            CSR_PLAYER_X:      px_ff    <= csr_data[18:0];
            CSR_PLAYER_Y:      py_ff    <= csr_data[18:0];
            CSR_PLAYER_ANGLE:  pang_ff  <= csr_data[15:0];
            CSR_SCREEN_WIDTH:  sw_ff    <= csr_data[9:0];
            CSR_SCREEN_HEIGHT: sh_ff    <= csr_data[9:0];
            CSR_STEP_SIZE:     step_ff  <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // shared restoring divider, one quotient bit per cycle
   logic [DIV_N-1:0]  dnum_ff, dquo_ff;
   logic [SQ_W/2:0]   drem_ff;    // remainder, one bit wider than divisor
   logic [SQ_W/2-1:0] dden_ff;
   logic [DIV_CW-1:0] dcnt_ff;
   logic [SQ_W/2:0]   dtrial;
   logic [SQ_W/2+1:0] dsub;

   // ray and march state
   logic [9:0]               col_ff;
   logic signed [15:0]       tc_ff, ts_ff;
   logic signed [POS_W-1:0]  rx_ff, ry_ff, ddx_ff, ddy_ff;
   logic [CNT_W-1:0]         n_ff;
   logic                     stop_ff, hit_ff;

   // square root
   logic [SQ_W-1:0]   sv_ff, sr_ff, sb_ff;
   logic [SQ_CW-1:0]  scnt_ff;
   logic [SQ_W/2-1:0] dist_ff;
   logic [POS_W-1:0]  ax_ff, ay_ff;

   // angle from divide quotient
   logic [15:0] ang_full;
   logic [15:0] grid;
   assign grid     = 16'hFFFF << (16 - TRIG_TABLE_BITS);
   assign ang_full = pang_ff + dquo_ff[15:0] - 16'(RAD_BAU / 2);

   assign dtrial = {drem_ff[SQ_W/2-1:0], dnum_ff[DIV_N-1]};
   assign dsub   = {1'b0, dtrial} - {2'b0, dden_ff};

   // trig unit: one multiply per cycle, cosine first, then sine
   logic [2:0]         tph_ff;
   logic               tsel_ff;
   logic [1:0]         tq_ff;
   logic [14:0]        tz_ff, tz2_ff;
   logic [15:0]        tt_ff;
   logic [15:0]        tang;
   logic [15:0]        ma, mb;
   logic [31:0]        tmul;
   logic signed [15:0] tval;

   always_comb begin
      tang = (ang_full & grid) + (tsel_ff ? 16'd0 : 16'd16384);
      unique case (tph_ff)
         TR_SQUARE: begin
            ma = {1'b0, tz_ff};
            mb = {1'b0, tz_ff};
         end
         TR_POLY_C: begin
            ma = 16'(SIN_C);
            mb = {1'b0, tz2_ff};
         end
         TR_POLY_B: begin
            ma = tt_ff;
            mb = {1'b0, tz2_ff};
         end
         TR_SCALE: begin
            ma = {1'b0, tz_ff};
            mb = tt_ff;
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
      tmul = ma * mb;
      tval = tq_ff[1] ? -$signed({1'b0, tmul[28:14]}) : $signed({1'b0, tmul[28:14]});
   end

   // step increments
   logic [15:0] mag_c, mag_s;
   logic [31:0] prod_c, prod_s;
   assign mag_c  = tc_ff[15] ? 16'(-tc_ff) : tc_ff;
   assign mag_s  = ts_ff[15] ? 16'(-ts_ff) : ts_ff;
   assign prod_c = mag_c * step_ff;
   assign prod_s = mag_s * step_ff;

   // stepping and cell test
   logic signed [POS_W-1:0] nx, ny;
   logic                    outx, outy, wall;
   logic [CELL_W-1:0]       cx, cy;
   logic [6:0]              bit_idx;

   function automatic logic out_of_map(input logic signed [POS_W-1:0] p);
      logic signed [POS_W-1:0] cidx;
      cidx = p >>> 16;
      if (p <= -$signed(POS_W'(65536))) return 1'b1;
      if (p < 0) return 1'b0;
      return (cidx >= POS_W'(MAP_DIM));
   endfunction

   always_comb begin
      nx   = rx_ff + ddx_ff;
      ny   = ry_ff + ddy_ff;
      outx = out_of_map(nx);
      outy = out_of_map(ny);
      cx   = nx[POS_W-1] ? '0 : nx[16 +: CELL_W];
      cy   = ny[POS_W-1] ? '0 : ny[16 +: CELL_W];
      bit_idx = 7'(cx * MAP_DIM) + 7'(cy);
      wall = walls_ff[bit_idx[5:0]];
   end

   // square root step
   logic [SQ_W-1:0] s_sum;
   assign s_sum = sr_ff + sb_ff;

   logic [SQ_W-1:0] sqx, sqy;
   assign sqx = ax_ff * ax_ff;
   assign sqy = ay_ff * ay_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         col_ff  <= req_column;
         dnum_ff <= DIV_N'(req_column) * DIV_N'(RAD_BAU);
         dden_ff <= (SQ_W/2)'((sw_ff == '0) ? 10'd1 : sw_ff);
         drem_ff <= '0;
         dquo_ff <= '0;
         dcnt_ff <= DIV_CW'(DIV_N);
         tph_ff  <= TR_ANGLE;
         tsel_ff <= 1'b0;
      end
      if (cmd.line_init) begin
         dnum_ff <= DIV_N'({sh_ff, 16'd0});
         dden_ff <= dist_ff;
         drem_ff <= '0;
         dquo_ff <= '0;
         dcnt_ff <= DIV_CW'(DIV_N);
      end
      if (cmd.div_step && dcnt_ff != '0) begin
         dnum_ff <= dnum_ff << 1;
         dcnt_ff <= dcnt_ff - 1'b1;
         if (!dsub[SQ_W/2+1]) begin
            drem_ff <= dsub[SQ_W/2:0];
            dquo_ff <= {dquo_ff[DIV_N-2:0], 1'b1};
         end else begin
            drem_ff <= dtrial;
            dquo_ff <= {dquo_ff[DIV_N-2:0], 1'b0};
         end
      end
      if (cmd.trig && tph_ff != TR_DONE) begin
         unique case (tph_ff)
            TR_ANGLE: begin
               tq_ff  <= tang[15:14];
               tz_ff  <= tang[14] ? (15'd16384 - {1'b0, tang[13:0]}) : {1'b0, tang[13:0]};
               tph_ff <= TR_SQUARE;
            end
            TR_SQUARE: begin
               tz2_ff <= tmul[28:14];
               tph_ff <= TR_POLY_C;
            end
            TR_POLY_C: begin
               tt_ff  <= 16'(SIN_B) - tmul[29:14];
               tph_ff <= TR_POLY_B;
            end
            TR_POLY_B: begin
               tt_ff  <= 16'(SIN_A) - tmul[29:14];
               tph_ff <= TR_SCALE;
            end
            TR_SCALE: begin
               if (tsel_ff) ts_ff <= tval;
               else         tc_ff <= tval;
               tsel_ff <= 1'b1;
               tph_ff  <= tsel_ff ? TR_DONE : TR_ANGLE;
            end
            default: ;
         endcase
      end
      if (cmd.delta) begin
         ddx_ff <= tc_ff[15] ? -$signed(POS_W'(prod_c[31:14]))
                             : $signed(POS_W'(prod_c[31:14]));
         ddy_ff <= ts_ff[15] ? -$signed(POS_W'(prod_s[31:14]))
                             : $signed(POS_W'(prod_s[31:14]));
         rx_ff  <= $signed(POS_W'(px_ff));
         ry_ff  <= $signed(POS_W'(py_ff));
         n_ff   <= '0;
         hit_ff <= 1'b0;
      end
      // advance one step; stop on wall, edge or step cap
      if (cmd.march && !stop_ff) begin
         if (n_ff == CNT_W'(MAX_STEPS)) begin
            hit_ff <= 1'b0;
         end else begin
            rx_ff <= nx;
            ry_ff <= ny;
            n_ff  <= n_ff + 1'b1;
            if (!(outx || outy) && wall) hit_ff <= 1'b1;
         end
      end
      if (cmd.square) begin
         sv_ff   <= sqx + sqy;
         sr_ff   <= '0;
         sb_ff   <= SQ_W'(1) << (SQ_W - 2);
         scnt_ff <= SQ_CW'(SQ_W / 2);
      end
      if (cmd.sqrt_step && scnt_ff != '0) begin
         scnt_ff <= scnt_ff - 1'b1;
         sb_ff   <= sb_ff >> 2;
         if (sv_ff >= s_sum) begin
            sv_ff <= sv_ff - s_sum;
            sr_ff <= (sr_ff >> 1) + sb_ff;
         end else begin
            sr_ff <= sr_ff >> 1;
         end
      end
      if (cmd.sqrt_step && scnt_ff == '0) dist_ff <= sr_ff[SQ_W/2-1:0];
   end

   // stop flag and distance magnitudes
   logic signed [POS_W-1:0] dxs, dys;
   assign dxs = rx_ff - $signed(POS_W'(px_ff));
   assign dys = ry_ff - $signed(POS_W'(py_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_ff <= 1'b0;
      end else if (cmd.delta) begin
         stop_ff <= 1'b0;
      end else if (cmd.march && !stop_ff) begin
         stop_ff <= (n_ff == CNT_W'(MAX_STEPS)) || outx || outy || wall;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff <= dxs[POS_W-1] ? POS_W'(-dxs) : POS_W'(dxs);
      ay_ff <= dys[POS_W-1] ? POS_W'(-dys) : POS_W'(dys);
   end

   // line span
   logic [16:0] lh;
   logic [15:0] half_h, half_lh;
   always_comb begin
      if (dist_ff == '0 || dquo_ff > DIV_N'(LINE_SAT)) lh = 17'(LINE_SAT);
      else                                             lh = dquo_ff[16:0];
      half_h  = 16'(sh_ff >> 1);
      half_lh = lh[16:1];
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_column_out  <= col_ff;
         rsp_wall_hit    <= hit_ff;
         rsp_line_top    <= hit_ff ? $signed(half_h - half_lh) : 16'sd0;
         rsp_line_bottom <= hit_ff ? $signed(half_h + half_lh) : 16'sd0;
      end
   end

   assign status.div_done   = (dcnt_ff == '0);
   assign status.trig_done  = (tph_ff == TR_DONE);
   assign status.sqrt_done  = (scnt_ff == '0);
   assign status.march_stop = stop_ff;
   assign status.hit        = hit_ff;

endmodule

[design/raycast_column_wall_height.sv]
// ----------------------------------------------------------------------------
// raycast_column_wall_height
// Casts one ray per screen column over a grid map and returns the wall span.
// ----------------------------------------------------------------------------
//  channel | ports                          | direction
//  req     | req_valid/ready, req_column    | in
//  rsp     | rsp_valid/ready, rsp_*         | out
//  csr     | csr_write, csr_index, csr_data | in, write only
//
// One column at a time: accept, angle divide and trig setup, then the march
// steps until a hit, the map edge or the step cap, then on a hit the squared
// distance, square root and line divide, and last the output rows are formed
// and presented. Reset restores the register defaults; a held result stalls
// the next column until rsp_ready.
module raycast_column_wall_height #(
   parameter int MAP_DIM         = 8,
   parameter int MAX_STEPS       = 2048,
   parameter int TRIG_TABLE_BITS = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [9:0]         req_column,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [9:0]         rsp_column_out,
   output logic               rsp_wall_hit,
   output logic signed [15:0] rsp_line_top,
   output logic signed [15:0] rsp_line_bottom
);
   import rcwh_pkg::*;

   cmd_type    cmd;
   status_type status;

   rcwh_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .status, .cmd
   );

   rcwh_datapath #(
      .MAP_DIM(MAP_DIM), .MAX_STEPS(MAX_STEPS), .TRIG_TABLE_BITS(TRIG_TABLE_BITS)
   ) u_dp (
      .clock, .reset, .csr_write, .csr_index, .csr_data, .req_column,
      .cmd, .status, .rsp_column_out, .rsp_wall_hit, .rsp_line_top,
      .rsp_line_bottom
   );

endmodule
